// ----- hdl/gnoise_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gnoise_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_1D    = 2'd1,
        KIND_2D    = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    localparam logic [7:0] BASE_PERM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    function automatic logic [7:0] base_at(logic [15:0] idx);
        return BASE_PERM[idx[7:0]];
    endfunction

    function automatic logic signed [19:0] slope2(logic [2:0] h, logic signed [17:0] dx,
                                                  logic signed [17:0] dy);
        logic signed [19:0] u;
        logic signed [19:0] v;
        logic signed [19:0] su;
        logic signed [19:0] sv;
        u  = h[2] ? 20'(dy) : 20'(dx);
        v  = h[2] ? 20'(dx) : 20'(dy);
        su = h[0] ? -u : u;
        sv = h[1] ? -(v <<< 1) : (v <<< 1);
        return su + sv;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gradient_noise_1d_2d.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Gradient noise in one and two dimensions at fixed-point coordinates.
// A request carries kind, x_coord, y_coord, entry_index and entry_value and is
// taken at a clock edge where req_valid is high and req_stall is low. Kind 1
// and kind 2 each give one noise_value, signed Q3.12, on the result channel;
// kind 0 writes one permutation table entry and kind 3 is dropped.
// The pipeline has seven register stages, and one request is taken in every
// cycle while req_stall is low. The three table lookups of a request (cell,
// then the chained corner hashes) go to three copies of the table, each with
// two read ports, in the first two stages.
// The whole pipeline moves as one; when noise_stall holds a waiting result,
// every stage holds and req_stall is raised, so nothing is lost or repeated.
// Reset empties the pipeline and returns the table to the base permutation
// at once by clearing one valid flag per entry; unwritten entries read from
// the base table. Table writes take effect for every later request.

module gradient_noise_1d_2d #(
    parameter int TABLE_SIZE    = 256,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic [1:0]         kind,
    input  wire logic [15:0]        x_coord,
    input  wire logic [15:0]        y_coord,
    input  wire logic [7:0]         entry_index,
    input  wire logic [7:0]         entry_value,
    output logic                    noise_valid,
    input  wire logic               noise_stall,
    output logic signed [15:0]      noise_value
);

    localparam int IW = $clog2(TABLE_SIZE);

    logic adv;
    logic wr_en;
    logic is_eval;
    logic [IW-1:0] wr_addr;
    logic [15:0] wr_idx;

    logic [31:0] xs;
    logic [31:0] ys;
    logic [31:0] xt32;
    logic [31:0] yt32;
    logic [IW-1:0] x_cell;
    logic [IW-1:0] x_cell1;
    logic [IW-1:0] y_cell;
    logic [15:0] x_t;
    logic [15:0] y_t;

    logic [7:0] ram0_a;
    logic [7:0] ram0_b;
    logic [7:0] ram1_a;
    logic [7:0] ram1_b;
    logic [7:0] ram2_a;
    logic [7:0] ram2_b;

    logic [TABLE_SIZE-1:0] known_reg;

    // Stage 1
    logic v1_reg;
    logic is2d1_reg;
    logic [15:0] tx1_reg;
    logic [15:0] ty1_reg;
    logic [IW-1:0] yc1_reg;
    logic [31:0] ttx1_reg;
    logic [31:0] tty1_reg;
    logic k0a_reg;
    logic k0b_reg;
    logic [7:0] b0a_reg;
    logic [7:0] b0b_reg;

    // Stage 2
    logic [7:0] hx;
    logic [7:0] hx1;
    logic [15:0] a_sum;
    logic [15:0] b_sum;
    logic [IW-1:0] addr_a;
    logic [IW-1:0] addr_a1;
    logic [IW-1:0] addr_b;
    logic [IW-1:0] addr_b1;
    logic [31:0] t3x_full;
    logic [31:0] t3y_full;
    logic [36:0] qx_full;
    logic [36:0] qy_full;
    logic v2_reg;
    logic is2d2_reg;
    logic [15:0] tx2_reg;
    logic [15:0] ty2_reg;
    logic h1a2_reg;
    logic h1b2_reg;
    logic [15:0] t3x2_reg;
    logic [15:0] t3y2_reg;
    logic [19:0] qx2_reg;
    logic [19:0] qy2_reg;
    logic k1a_reg;
    logic k1b_reg;
    logic k2a_reg;
    logic k2b_reg;
    logic [7:0] b1a_reg;
    logic [7:0] b1b_reg;
    logic [7:0] b2a_reg;
    logic [7:0] b2b_reg;

    // Stage 3
    logic [35:0] ex_full;
    logic [35:0] ey_full;
    logic [7:0] h_aa;
    logic [7:0] h_ab;
    logic [7:0] h_ba;
    logic [7:0] h_bb;
    logic signed [17:0] dx0;
    logic signed [17:0] dx1;
    logic signed [17:0] dy0;
    logic signed [17:0] dy1;
    logic signed [19:0] ga_next;
    logic signed [19:0] gb_next;
    logic v3_reg;
    logic is2d3_reg;
    logic [16:0] ex3_reg;
    logic [16:0] ey3_reg;
    logic signed [19:0] ga3_reg;
    logic signed [19:0] gb3_reg;
    logic signed [19:0] gc3_reg;
    logic signed [19:0] gd3_reg;

    // Stage 4
    logic signed [20:0] d1;
    logic signed [20:0] d2;
    logic v4_reg;
    logic is2d4_reg;
    logic [16:0] ey4_reg;
    logic signed [19:0] ga4_reg;
    logic signed [19:0] gc4_reg;
    logic signed [38:0] pr1_4_reg;
    logic signed [38:0] pr2_4_reg;

    // Stage 5
    logic v5_reg;
    logic is2d5_reg;
    logic [16:0] ey5_reg;
    logic signed [21:0] s1_5_reg;
    logic signed [21:0] s2_5_reg;

    // Stage 6
    logic signed [22:0] d3;
    logic v6_reg;
    logic is2d6_reg;
    logic signed [21:0] s1_6_reg;
    logic signed [40:0] pr3_6_reg;

    // Stage 7
    logic signed [25:0] r_sum;
    logic signed [21:0] r_scaled;
    logic signed [15:0] noise_next;
    logic noise_valid_reg;
    logic signed [15:0] noise_value_reg;

    assign adv       = !noise_valid_reg || !noise_stall;
    assign req_stall = !adv;
    assign is_eval   = (kind == gnoise_pkg::KIND_1D) || (kind == gnoise_pkg::KIND_2D);
    assign wr_en     = adv && req_valid && (kind == gnoise_pkg::KIND_WRITE);
    assign wr_idx    = 16'(entry_index);
    assign wr_addr   = wr_idx[IW-1:0];

    always_comb
    begin
        xs      = 32'(x_coord) >> FRACTION_BITS;
        ys      = 32'(y_coord) >> FRACTION_BITS;
        xt32    = 32'(x_coord) << (16 - FRACTION_BITS);
        yt32    = 32'(y_coord) << (16 - FRACTION_BITS);
        x_cell  = xs[IW-1:0];
        y_cell  = ys[IW-1:0];
        x_cell1 = x_cell + IW'(1);
        x_t     = xt32[15:0];
        y_t     = yt32[15:0];
    end

    always_comb
    begin
        hx       = k0a_reg ? ram0_a : b0a_reg;
        hx1      = k0b_reg ? ram0_b : b0b_reg;
        a_sum    = 16'(hx) + 16'(yc1_reg);
        b_sum    = 16'(hx1) + 16'(yc1_reg);
        addr_a   = a_sum[IW-1:0];
        addr_b   = b_sum[IW-1:0];
        addr_a1  = addr_a + IW'(1);
        addr_b1  = addr_b + IW'(1);
        t3x_full = 32'(ttx1_reg[31:16]) * 32'(tx1_reg);
        t3y_full = 32'(tty1_reg[31:16]) * 32'(ty1_reg);
        qx_full  = ((37'(ttx1_reg) * 37'd6) + 37'd42949672960)
                   - ((37'(tx1_reg) * 37'd15) << 16);
        qy_full  = ((37'(tty1_reg) * 37'd6) + 37'd42949672960)
                   - ((37'(ty1_reg) * 37'd15) << 16);
    end

    always_comb
    begin
        ex_full = 36'(t3x2_reg) * 36'(qx2_reg);
        ey_full = 36'(t3y2_reg) * 36'(qy2_reg);
        h_aa    = k1a_reg ? ram1_a : b1a_reg;
        h_ab    = k1b_reg ? ram1_b : b1b_reg;
        h_ba    = k2a_reg ? ram2_a : b2a_reg;
        h_bb    = k2b_reg ? ram2_b : b2b_reg;
        dx0     = $signed({2'b00, tx2_reg});
        dy0     = $signed({2'b00, ty2_reg});
        dx1     = dx0 - 18'sd65536;
        dy1     = dy0 - 18'sd65536;
        if (is2d2_reg)
        begin
            ga_next = gnoise_pkg::slope2(h_aa[2:0], dx0, dy0);
            gb_next = gnoise_pkg::slope2(h_ba[2:0], dx1, dy0);
        end
        else
        begin
            ga_next = h1a2_reg ? -20'(dx0) : 20'(dx0);
            gb_next = h1b2_reg ? -20'(dx1) : 20'(dx1);
        end
    end

    always_comb
    begin
        d1 = 21'(gb3_reg) - 21'(ga3_reg);
        d2 = 21'(gd3_reg) - 21'(gc3_reg);
        d3 = 23'(s2_5_reg) - 23'(s1_5_reg);
    end

    always_comb
    begin
        if (is2d6_reg)
        begin
            r_sum = 26'(s1_6_reg) + 26'($signed(pr3_6_reg[40:16]));
        end
        else
        begin
            r_sum = 26'(s1_6_reg);
        end
        r_scaled = $signed(r_sum[25:4]);
        if (r_scaled > 22'sd32767)
        begin
            noise_next = 16'sh7fff;
        end
        else if (r_scaled < -22'sd32768)
        begin
            noise_next = -16'sh8000;
        end
        else
        begin
            noise_next = 16'(r_scaled);
        end
    end

    gnoise_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_SIZE)
    ) u_ram0 (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (entry_value),
        .rd_en     (adv),
        .rd_addr_a (x_cell),
        .rd_addr_b (x_cell1),
        .rd_data_a (ram0_a),
        .rd_data_b (ram0_b)
    );

    gnoise_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_SIZE)
    ) u_ram1 (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (entry_value),
        .rd_en     (adv),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_a1),
        .rd_data_a (ram1_a),
        .rd_data_b (ram1_b)
    );

    gnoise_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_SIZE)
    ) u_ram2 (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (entry_value),
        .rd_en     (adv),
        .rd_addr_a (addr_b),
        .rd_addr_b (addr_b1),
        .rd_data_a (ram2_a),
        .rd_data_b (ram2_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg       <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            v5_reg          <= 1'b0;
            v6_reg          <= 1'b0;
            noise_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                known_reg[wr_addr] <= 1'b1;
            end
            if (adv)
            begin
                v1_reg          <= req_valid && is_eval;
                v2_reg          <= v1_reg;
                v3_reg          <= v2_reg;
                v4_reg          <= v3_reg;
                v5_reg          <= v4_reg;
                v6_reg          <= v5_reg;
                noise_valid_reg <= v6_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            is2d1_reg <= (kind == gnoise_pkg::KIND_2D);
            tx1_reg   <= x_t;
            ty1_reg   <= y_t;
            yc1_reg   <= y_cell;
            ttx1_reg  <= 32'(x_t) * 32'(x_t);
            tty1_reg  <= 32'(y_t) * 32'(y_t);
            k0a_reg   <= known_reg[x_cell];
            k0b_reg   <= known_reg[x_cell1];
            b0a_reg   <= gnoise_pkg::base_at(16'(x_cell));
            b0b_reg   <= gnoise_pkg::base_at(16'(x_cell1));

            is2d2_reg <= is2d1_reg;
            tx2_reg   <= tx1_reg;
            ty2_reg   <= ty1_reg;
            h1a2_reg  <= hx[0];
            h1b2_reg  <= hx1[0];
            t3x2_reg  <= t3x_full[31:16];
            t3y2_reg  <= t3y_full[31:16];
            qx2_reg   <= qx_full[35:16];
            qy2_reg   <= qy_full[35:16];
            k1a_reg   <= known_reg[addr_a];
            k1b_reg   <= known_reg[addr_a1];
            k2a_reg   <= known_reg[addr_b];
            k2b_reg   <= known_reg[addr_b1];
            b1a_reg   <= gnoise_pkg::base_at(16'(addr_a));
            b1b_reg   <= gnoise_pkg::base_at(16'(addr_a1));
            b2a_reg   <= gnoise_pkg::base_at(16'(addr_b));
            b2b_reg   <= gnoise_pkg::base_at(16'(addr_b1));

            is2d3_reg <= is2d2_reg;
            ex3_reg   <= ex_full[32:16];
            ey3_reg   <= ey_full[32:16];
            ga3_reg   <= ga_next;
            gb3_reg   <= gb_next;
            gc3_reg   <= gnoise_pkg::slope2(h_ab[2:0], dx0, dy1);
            gd3_reg   <= gnoise_pkg::slope2(h_bb[2:0], dx1, dy1);

            is2d4_reg <= is2d3_reg;
            ey4_reg   <= ey3_reg;
            ga4_reg   <= ga3_reg;
            gc4_reg   <= gc3_reg;
            pr1_4_reg <= 39'(d1) * 39'($signed({1'b0, ex3_reg}));
            pr2_4_reg <= 39'(d2) * 39'($signed({1'b0, ex3_reg}));

            is2d5_reg <= is2d4_reg;
            ey5_reg   <= ey4_reg;
            s1_5_reg  <= 22'(23'(ga4_reg) + $signed(pr1_4_reg[38:16]));
            s2_5_reg  <= 22'(23'(gc4_reg) + $signed(pr2_4_reg[38:16]));

            is2d6_reg <= is2d5_reg;
            s1_6_reg  <= s1_5_reg;
            pr3_6_reg <= 41'(d3) * 41'($signed({1'b0, ey5_reg}));

            noise_value_reg <= noise_next;
        end
    end

    assign noise_valid = noise_valid_reg;
    assign noise_value = noise_value_reg;

endmodule

`default_nettype wire

// ----- hdl/gnoise_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gnoise_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] data_a_reg;
    logic [WIDTH-1:0] data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_a_reg <= mem[rd_addr_a];
            data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = data_a_reg;
    assign rd_data_b = data_b_reg;

endmodule

`default_nettype wire
